@@ rtl/fmprc_pkg.sv @@
// ----------------------------------------------------------------------------
// First-match packet rule classifier package
// Shared request, result and token types, codes and default sizes.
// ----------------------------------------------------------------------------
package fmprc_pkg;

   localparam int DEF_RULE_SLOTS  = 64;
   localparam int DEF_CHAIN_COUNT = 3;

   // Request kinds
   localparam logic REQ_ADD      = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   // Rule actions
   localparam logic [1:0] ACT_ACCEPT  = 2'd0;
   localparam logic [1:0] ACT_DROP    = 2'd1;
   localparam logic [1:0] ACT_LOG     = 2'd2;
   localparam logic [1:0] ACT_INVALID = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // Classify verdicts
   localparam logic VERDICT_ACCEPT = 1'b0;
   localparam logic VERDICT_DROP   = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [1:0]  chain_id;
      logic [31:0] src_addr;
      logic [31:0] src_mask;
      logic [31:0] dst_addr;
      logic [31:0] dst_mask;
      logic [7:0]  proto_num;
      logic [15:0] dest_port;
      logic [1:0]  verdict_in;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       verdict_out;
   } rsp_payload_type;

   // A request on its way down the row of rule cells, with its answer once decided.
   typedef struct packed {
      req_payload_type req;
      logic            done;
      logic [1:0]      status;
      logic            verdict;
   } token_type;

endpackage

@@ rtl/fmprc_cell.sv @@
// ----------------------------------------------------------------------------
// Rule cell
// Holds one rule slot and one pipeline stage of the request chain.
// ----------------------------------------------------------------------------
module fmprc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  fmprc_pkg::token_type up_tok,
   output logic               dn_valid,
   output fmprc_pkg::token_type dn_tok,
   output logic               slot_used
);
   import fmprc_pkg::*;

   logic        tok_valid_ff;
   token_type   tok_ff;
   token_type   tok_in;
   logic        rule_valid_ff;
   logic [1:0]  rule_chain_ff;
   logic [31:0] rule_src_ff;
   logic [31:0] rule_src_mask_ff;
   logic [31:0] rule_dst_ff;
   logic [31:0] rule_dst_mask_ff;
   logic [7:0]  rule_proto_ff;
   logic [15:0] rule_port_ff;
   logic [1:0]  rule_action_ff;
   logic        rule_hit;
   logic        rule_write;
   logic        open_req;

   always_comb begin
      open_req = up_valid && !up_tok.done;
      rule_hit = rule_valid_ff
         && (rule_chain_ff == up_tok.req.chain_id)
         && (((up_tok.req.src_addr ^ rule_src_ff) & rule_src_mask_ff) == 32'd0)
         && (((up_tok.req.dst_addr ^ rule_dst_ff) & rule_dst_mask_ff) == 32'd0)
         && ((rule_proto_ff == 8'd0) || (rule_proto_ff == up_tok.req.proto_num))
         && ((rule_port_ff == 16'd0) || (rule_port_ff == up_tok.req.dest_port))
         && (rule_action_ff != ACT_LOG);
      // Slots fill from the bottom and are never freed, so the first empty
      // slot an add request meets is the lowest free one.
      rule_write = advance && open_req && (up_tok.req.req_type == REQ_ADD) && !rule_valid_ff;

      tok_in = up_tok;
      if (open_req) begin
         if (up_tok.req.req_type == REQ_ADD) begin
            if (!rule_valid_ff) begin
               tok_in.done    = 1'b1;
               tok_in.status  = STATUS_OK;
               tok_in.verdict = VERDICT_ACCEPT;
            end
         end else if (rule_hit) begin
            tok_in.done    = 1'b1;
            tok_in.status  = STATUS_OK;
            tok_in.verdict = (rule_action_ff == ACT_DROP) ? VERDICT_DROP : VERDICT_ACCEPT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff  <= 1'b0;
         rule_valid_ff <= 1'b0;
      end else if (advance) begin
         tok_valid_ff <= up_valid;
         if (rule_write) begin
            rule_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff <= tok_in;
      end
      if (rule_write) begin
         rule_chain_ff    <= up_tok.req.chain_id;
         rule_src_ff      <= up_tok.req.src_addr;
         rule_src_mask_ff <= up_tok.req.src_mask;
         rule_dst_ff      <= up_tok.req.dst_addr;
         rule_dst_mask_ff <= up_tok.req.dst_mask;
         rule_proto_ff    <= up_tok.req.proto_num;
         rule_port_ff     <= up_tok.req.dest_port;
         rule_action_ff   <= up_tok.req.verdict_in;
      end
   end

   assign dn_valid  = tok_valid_ff;
   assign dn_tok    = tok_ff;
   assign slot_used = rule_valid_ff;

endmodule

@@ rtl/first_match_packet_rule_classifier_core.sv @@
// ----------------------------------------------------------------------------
// First-match packet rule classifier core
// Rule table built as a row of cells that requests travel through in order.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Direction  Moves
//  request   req_valid, req_stall, req_data  in         add rule or classify packet
//  response  rsp_valid, rsp_stall, rsp_data  out        status and verdict
//
// One request is taken per cycle while the response is not stalled; each
// passes through one register per rule cell and then the output register.
// Reset clears every slot's valid bit at once; rule contents are not reset.
// A stalled response freezes the whole cell row, which stalls the request side.
// ----------------------------------------------------------------------------
module first_match_packet_rule_classifier_core #(
   parameter int RULE_SLOTS  = fmprc_pkg::DEF_RULE_SLOTS,
   parameter int CHAIN_COUNT = fmprc_pkg::DEF_CHAIN_COUNT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fmprc_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fmprc_pkg::rsp_payload_type rsp_data
);
   import fmprc_pkg::*;

   logic            advance;
   logic            chain_vld [RULE_SLOTS+1];
   token_type       chain_tok [RULE_SLOTS+1];
   logic [RULE_SLOTS-1:0] used_vec;
   logic            bad_req;
   token_type       head_tok;
   token_type       last_tok;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // A bad chain, or a bad action on an add, is decided before the row.
   always_comb begin
      bad_req = ({1'b0, req_data.chain_id} >= 3'(CHAIN_COUNT))
         || ((req_data.req_type == REQ_ADD) && (req_data.verdict_in == ACT_INVALID));
      head_tok.req     = req_data;
      head_tok.done    = bad_req;
      head_tok.status  = bad_req ? STATUS_INVALID : STATUS_OK;
      head_tok.verdict = VERDICT_ACCEPT;
   end

   assign chain_vld[0] = req_valid;
   assign chain_tok[0] = head_tok;

   for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
      fmprc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .up_valid  (chain_vld[i]),
         .up_tok    (chain_tok[i]),
         .dn_valid  (chain_vld[i+1]),
         .dn_tok    (chain_tok[i+1]),
         .slot_used (used_vec[i])
      );
   end

   // An add that found no free slot means a full table; an undecided
   // classify falls through to accept.
   always_comb begin
      last_tok = chain_tok[RULE_SLOTS];
      if (last_tok.done) begin
         rsp_in.status      = last_tok.status;
         rsp_in.verdict_out = last_tok.verdict;
      end else if (last_tok.req.req_type == REQ_ADD) begin
         rsp_in.status      = STATUS_FULL;
         rsp_in.verdict_out = VERDICT_ACCEPT;
      end else begin
         rsp_in.status      = STATUS_OK;
         rsp_in.verdict_out = VERDICT_ACCEPT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_vld[RULE_SLOTS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_slots_fill_in_order: assert property (@(posedge clock) disable iff (reset)
      (used_vec & (used_vec + {{(RULE_SLOTS-1){1'b0}}, 1'b1})) == '0)
      else $error("rule slots are not filled from the lowest slot upwards");

   a_one_add_per_cycle: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(used_vec) <= $countones($past(used_vec)) + 1))
      else $error("more than one rule written in a cycle");

   a_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(used_vec))
      else $error("rule table changed while the response side was stalled");
`endif

endmodule
